@@ rtl/sqv_pkg.sv @@
// ----------------------------------------------------------------------------
// sqv_pkg
// Shared types, constants and helper functions of the sprite quad vertex setup.
// ----------------------------------------------------------------------------
package sqv_pkg;

    // quarter-wave sine table geometry (depth is a power of two)
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_LOG         = $clog2(SINE_TABLE_DEPTH);

    // Q2.30 value of pi/2
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    // taylor term divisors 2k(2k+1) as reciprocals, exact for terms below 2^32
    localparam int              TAYLOR_SHIFT = 41;
    localparam longint unsigned RECIP_D1  = ((64'd1 << TAYLOR_SHIFT) + 64'd5) / 64'd6;
    localparam longint unsigned RECIP_D2  = ((64'd1 << TAYLOR_SHIFT) + 64'd19) / 64'd20;
    localparam longint unsigned RECIP_D3  = ((64'd1 << TAYLOR_SHIFT) + 64'd41) / 64'd42;
    localparam longint unsigned RECIP_D4  = ((64'd1 << TAYLOR_SHIFT) + 64'd71) / 64'd72;
    localparam longint unsigned RECIP_D5  = ((64'd1 << TAYLOR_SHIFT) + 64'd109) / 64'd110;
    localparam longint unsigned RECIP_D6  = ((64'd1 << TAYLOR_SHIFT) + 64'd155) / 64'd156;
    localparam longint unsigned RECIP_D7  = ((64'd1 << TAYLOR_SHIFT) + 64'd209) / 64'd210;
    localparam longint unsigned RECIP_D8  = ((64'd1 << TAYLOR_SHIFT) + 64'd271) / 64'd272;
    localparam longint unsigned RECIP_D9  = ((64'd1 << TAYLOR_SHIFT) + 64'd341) / 64'd342;
    localparam longint unsigned RECIP_D10 = ((64'd1 << TAYLOR_SHIFT) + 64'd419) / 64'd420;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_TEX_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_TEX_HEIGHT = 1'd1;

    localparam logic [23:0] INV_TEX_RESET = 24'd65536;
    localparam logic [16:0] PIVOT_ONE     = 17'd65536;
    localparam logic [16:0] TEX_MAX       = 17'd131071;

    // corner codes
    localparam logic [1:0] CORNER_BR = 2'd3;

    typedef logic [15:0] t_sine_rom [0:SINE_TABLE_DEPTH];

    // sprite-level values after the first stage
    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic [16:0]        pxc;
        logic [16:0]        pyc;
        logic [27:0]        w;
        logic [27:0]        h;
        logic [36:0]        prod_ul;
        logic [36:0]        prod_ur;
        logic [36:0]        prod_vt;
        logic [36:0]        prod_vb;
        logic signed [16:0] sn;
        logic signed [16:0] cs;
        logic               rot;
    } t_sprite;

    // one corner vertex entering the rotation stages
    typedef struct packed {
        logic [1:0]         corner;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic [16:0]        u;
        logic [16:0]        v;
        logic signed [16:0] sn;
        logic signed [16:0] cs;
        logic               rot;
    } t_vertex;

    // reciprocal of the k-th taylor divisor
    function automatic longint unsigned f_taylor_recip(input int k);
        longint unsigned m;
        case (k)
            1:       m = RECIP_D1;
            2:       m = RECIP_D2;
            3:       m = RECIP_D3;
            4:       m = RECIP_D4;
            5:       m = RECIP_D5;
            6:       m = RECIP_D6;
            7:       m = RECIP_D7;
            8:       m = RECIP_D8;
            9:       m = RECIP_D9;
            10:      m = RECIP_D10;
            default: m = 64'd0;
        endcase
        return m;
    endfunction

    // sine table built at elaboration by a truncating Taylor series in Q2.30
    function automatic t_sine_rom f_build_sine();
        t_sine_rom          rom;
        longint unsigned    x;
        longint unsigned    t;
        longint unsigned    sum;
        logic [95:0]        prod;
        logic               neg;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            if (i >= SINE_TABLE_DEPTH) begin
                rom[i] = 16'd32768;
            end else if (i == 0) begin
                rom[i] = 16'd0;
            end else begin
                x   = (PI_HALF_Q30 * longint'(i)) >> SINE_LOG;
                t   = x;
                sum = x;
                neg = 1'b1;
                for (int k = 1; k <= 10; k++) begin
                    t    = (t * x) >> 30;
                    t    = (t * x) >> 30;
                    prod = 96'(t) * 96'(f_taylor_recip(k));
                    t    = 64'(prod >> TAYLOR_SHIFT);
                    if (neg) begin
                        sum = sum - t;
                    end else begin
                        sum = sum + t;
                    end
                    neg = !neg;
                end
                sum = (sum + 64'd16384) >> 15;
                if (sum > 64'd32768) begin
                    sum = 64'd32768;
                end
                rom[i] = sum[15:0];
            end
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = f_build_sine();

    // signed Q2.15 sine of a 16-bit angle
    function automatic logic signed [16:0] f_sine(input logic [15:0] a);
        logic [13+SINE_LOG:0] ph;
        logic [SINE_LOG-1:0]  idx;
        logic [SINE_LOG:0]    ent;
        logic [15:0]          mag;
        ph  = {a[13:0], {SINE_LOG{1'b0}}} >> 14;
        idx = ph[SINE_LOG-1:0];
        ent = a[14] ? ((SINE_LOG+1)'(SINE_TABLE_DEPTH) - {1'b0, idx}) : {1'b0, idx};
        mag = SINE_ROM[ent];
        return a[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    // saturate a texture product to unsigned Q1.16
    function automatic logic [16:0] f_sat_tex(input logic [36:0] p);
        return (p[36:25] != 12'd0) ? TEX_MAX : p[24:8];
    endfunction

    // saturate a position to signed Q16.8
    function automatic logic [23:0] f_sat_vert(input logic signed [36:0] v);
        logic [23:0] r;
        if (v > 37'sd8388607) begin
            r = 24'h7FFFFF;
        end else if (v < -37'sd8388608) begin
            r = 24'h800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/sprite_quad_vertex_setup.sv @@
// ----------------------------------------------------------------------------
// sprite_quad_vertex_setup
// Turns one sprite into four textured corner vertices.
// ----------------------------------------------------------------------------
// Usage:
//   Sprites arrive on the input channel (i_in_valid / o_in_ready), one
//   transfer per sprite. Each sprite leaves as four vertex transfers on the
//   output channel (o_out_valid / i_out_ready) in the order top-left,
//   top-right, bottom-left, bottom-right, with o_last on the fourth.
//   The two reciprocal texture sizes are written on the configuration
//   channel (index 0 width, index 1 height), which is always ready; the user
//   must write them only while the block is idle, which it does not enforce.
//   Pipeline: setup stage, corner walk, vertex stage, product stage and
//   output register. The vertices follow one per cycle while the receiver
//   is ready. The single output channel carries one vertex per cycle, so
//   each sprite holds it for its four vertices, while the setup stage can
//   already take the next sprite.
//   Reset (synchronous, active low) empties the pipeline and sets both
//   reciprocals to 65536.
//   When the receiver stalls, the vertex stages hold in place; the setup
//   stage keeps taking one sprite until it too is full.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_setup import sqv_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [23:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [15:0]   i_anchor_x,
    input  logic signed [15:0]   i_anchor_y,
    input  logic [11:0]          i_src_x,
    input  logic [11:0]          i_src_y,
    input  logic [11:0]          i_src_w,
    input  logic [11:0]          i_src_h,
    input  logic [16:0]          i_pivot_x,
    input  logic [16:0]          i_pivot_y,
    input  logic [15:0]          i_scale_x,
    input  logic [15:0]          i_scale_y,
    input  logic [1:0]           i_flip,
    input  logic [15:0]          i_angle,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_corner,
    output logic signed [23:0]   o_vert_x,
    output logic signed [23:0]   o_vert_y,
    output logic [16:0]          o_tex_u,
    output logic [16:0]          o_tex_v,
    output logic                 o_last
);

    logic    s1_valid;
    t_sprite s1_sprite;
    logic    s1_take;
    logic    adv;
    logic    v_valid;
    t_vertex v_vert;
    logic [23:0] vert_x, vert_y;

    // sprite setup stage
    sqv_setup u_setup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_anchor_x  (i_anchor_x),
        .i_anchor_y  (i_anchor_y),
        .i_src_x     (i_src_x),
        .i_src_y     (i_src_y),
        .i_src_w     (i_src_w),
        .i_src_h     (i_src_h),
        .i_pivot_x   (i_pivot_x),
        .i_pivot_y   (i_pivot_y),
        .i_scale_x   (i_scale_x),
        .i_scale_y   (i_scale_y),
        .i_flip      (i_flip),
        .i_angle     (i_angle),
        .i_take      (s1_take),
        .o_valid     (s1_valid),
        .o_sprite    (s1_sprite)
    );

    // placement and corner walk
    sqv_corner u_corner (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s1_valid),
        .i_sprite (s1_sprite),
        .o_take   (s1_take),
        .i_adv    (adv),
        .o_valid  (v_valid),
        .o_vert   (v_vert)
    );

    // rotation and output register
    sqv_rotate u_rotate (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (v_valid),
        .i_vert      (v_vert),
        .o_adv       (adv),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_corner    (o_corner),
        .o_vert_x    (vert_x),
        .o_vert_y    (vert_y),
        .o_tex_u     (o_tex_u),
        .o_tex_v     (o_tex_v),
        .o_last      (o_last)
    );

    assign o_vert_x = $signed(vert_x);
    assign o_vert_y = $signed(vert_y);

endmodule

@@ rtl/sqv_setup.sv @@
// ----------------------------------------------------------------------------
// sqv_setup
// Configuration registers and the first sprite stage: sizes, texture
// products and sine/cosine lookup.
// ----------------------------------------------------------------------------
module sqv_setup import sqv_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [23:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [15:0]   i_anchor_x,
    input  logic signed [15:0]   i_anchor_y,
    input  logic [11:0]          i_src_x,
    input  logic [11:0]          i_src_y,
    input  logic [11:0]          i_src_w,
    input  logic [11:0]          i_src_h,
    input  logic [16:0]          i_pivot_x,
    input  logic [16:0]          i_pivot_y,
    input  logic [15:0]          i_scale_x,
    input  logic [15:0]          i_scale_y,
    input  logic [1:0]           i_flip,
    input  logic [15:0]          i_angle,
    input  logic                 i_take,
    output logic                 o_valid,
    output t_sprite              o_sprite
);

    logic [23:0] r_inv_w;
    logic [23:0] r_inv_h;
    logic        r_valid;
    t_sprite     r_sprite;
    t_sprite     n_sprite;
    logic [12:0] lo_x, hi_x, lo_y, hi_y;

    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_w <= INV_TEX_RESET;
            r_inv_h <= INV_TEX_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INV_TEX_WIDTH:  r_inv_w <= i_cfg_data;
                CFG_INV_TEX_HEIGHT: r_inv_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1 datapath
    always_comb begin
        lo_x = {1'b0, i_src_x};
        hi_x = {1'b0, i_src_x} + {1'b0, i_src_w};
        lo_y = {1'b0, i_src_y};
        hi_y = {1'b0, i_src_y} + {1'b0, i_src_h};
        n_sprite.ax      = i_anchor_x;
        n_sprite.ay      = i_anchor_y;
        n_sprite.pxc     = (i_pivot_x > PIVOT_ONE) ? PIVOT_ONE : i_pivot_x;
        n_sprite.pyc     = (i_pivot_y > PIVOT_ONE) ? PIVOT_ONE : i_pivot_y;
        n_sprite.w       = i_src_w * i_scale_x;
        n_sprite.h       = i_src_h * i_scale_y;
        n_sprite.prod_ul = (i_flip[0] ? hi_x : lo_x) * r_inv_w;
        n_sprite.prod_ur = (i_flip[0] ? lo_x : hi_x) * r_inv_w;
        n_sprite.prod_vt = (i_flip[1] ? hi_y : lo_y) * r_inv_h;
        n_sprite.prod_vb = (i_flip[1] ? lo_y : hi_y) * r_inv_h;
        n_sprite.sn      = f_sine(i_angle);
        n_sprite.cs      = f_sine(i_angle + 16'd16384);
        n_sprite.rot     = (i_angle != 16'd0);
    end

    assign o_in_ready = !r_valid || i_take;

    // stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_sprite <= n_sprite;
        end
    end

    assign o_valid  = r_valid;
    assign o_sprite = r_sprite;

endmodule

@@ rtl/sqv_corner.sv @@
// ----------------------------------------------------------------------------
// sqv_corner
// Places the quad on the anchor and steps through the four corners,
// one vertex per cycle while the rotation stages advance.
// ----------------------------------------------------------------------------
module sqv_corner import sqv_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_sprite i_sprite,
    output logic    o_take,
    input  logic    i_adv,
    output logic    o_valid,
    output t_vertex o_vert
);

    logic               r_valid;
    logic [1:0]         r_cnt;
    logic signed [31:0] r_left, r_top;
    logic [27:0]        r_w, r_h;
    logic [16:0]        r_ul, r_ur, r_vt, r_vb;
    logic signed [15:0] r_ax, r_ay;
    logic signed [16:0] r_sn, r_cs;
    logic               r_rot;

    logic               r_vvalid;
    t_vertex            r_vert;
    t_vertex            n_vert;

    logic [44:0]        pw, ph;
    logic signed [46:0] diff_x, diff_y;
    logic               free;

    // placement: top-left floored to whole pixels
    always_comb begin
        pw     = i_sprite.pxc * i_sprite.w;
        ph     = i_sprite.pyc * i_sprite.h;
        diff_x = $signed({{7{i_sprite.ax[15]}}, i_sprite.ax, 24'b0}) - $signed({2'b00, pw});
        diff_y = $signed({{7{i_sprite.ay[15]}}, i_sprite.ay, 24'b0}) - $signed({2'b00, ph});
    end

    assign free   = !r_valid || (i_adv && (r_cnt == CORNER_BR));
    assign o_take = free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= 2'd0;
        end else if (free) begin
            r_valid <= i_valid;
            r_cnt   <= 2'd0;
        end else if (i_adv) begin
            r_cnt   <= r_cnt + 2'd1;
        end
    end

    // sprite register for the corner walk
    always_ff @(posedge i_clk) begin
        if (free && i_valid) begin
            r_left <= $signed({diff_x[46], diff_x[46:24], 8'b0});
            r_top  <= $signed({diff_y[46], diff_y[46:24], 8'b0});
            r_w    <= i_sprite.w;
            r_h    <= i_sprite.h;
            r_ul   <= f_sat_tex(i_sprite.prod_ul);
            r_ur   <= f_sat_tex(i_sprite.prod_ur);
            r_vt   <= f_sat_tex(i_sprite.prod_vt);
            r_vb   <= f_sat_tex(i_sprite.prod_vb);
            r_ax   <= i_sprite.ax;
            r_ay   <= i_sprite.ay;
            r_sn   <= i_sprite.sn;
            r_cs   <= i_sprite.cs;
            r_rot  <= i_sprite.rot;
        end
    end

    // corner vertex and its offset from the anchor
    always_comb begin
        n_vert.corner = r_cnt;
        n_vert.vx     = r_left + (r_cnt[0] ? $signed({4'b0, r_w}) : 32'sd0);
        n_vert.vy     = r_top  + (r_cnt[1] ? $signed({4'b0, r_h}) : 32'sd0);
        n_vert.dx     = n_vert.vx - $signed({{8{r_ax[15]}}, r_ax, 8'b0});
        n_vert.dy     = n_vert.vy - $signed({{8{r_ay[15]}}, r_ay, 8'b0});
        n_vert.ax     = r_ax;
        n_vert.ay     = r_ay;
        n_vert.u      = r_cnt[0] ? r_ur : r_ul;
        n_vert.v      = r_cnt[1] ? r_vb : r_vt;
        n_vert.sn     = r_sn;
        n_vert.cs     = r_cs;
        n_vert.rot    = r_rot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vvalid <= 1'b0;
        end else if (i_adv) begin
            r_vvalid <= r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_vert <= n_vert;
        end
    end

    assign o_valid = r_vvalid;
    assign o_vert  = r_vert;

endmodule

@@ rtl/sqv_rotate.sv @@
// ----------------------------------------------------------------------------
// sqv_rotate
// Rotates each vertex about the anchor when the sprite angle is nonzero,
// saturates it and holds the result in the output register.
// ----------------------------------------------------------------------------
module sqv_rotate import sqv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_vertex     i_vert,
    output logic        o_adv,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_corner,
    output logic [23:0] o_vert_x,
    output logic [23:0] o_vert_y,
    output logic [16:0] o_tex_u,
    output logic [16:0] o_tex_v,
    output logic        o_last
);

    logic               adv;
    logic               r_pvalid;
    logic signed [48:0] r_xc, r_ys, r_yc, r_xs;
    logic signed [31:0] r_vx, r_vy;
    logic signed [15:0] r_ax, r_ay;
    logic [1:0]         r_pcorner;
    logic [16:0]        r_pu, r_pv;
    logic               r_prot;

    logic               r_out_valid;
    logic [1:0]         r_corner;
    logic [23:0]        r_vert_x, r_vert_y;
    logic [16:0]        r_tex_u, r_tex_v;

    logic signed [49:0] sum_x, sum_y;
    logic signed [36:0] rot_x, rot_y, n_x, n_y;

    // whole vertex pipe moves when the output register can take a vertex
    assign adv   = !r_out_valid || i_out_ready;
    assign o_adv = adv;

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
        end else if (adv) begin
            r_pvalid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_xc      <= i_vert.dx * i_vert.cs;
            r_ys      <= i_vert.dy * i_vert.sn;
            r_yc      <= i_vert.dy * i_vert.cs;
            r_xs      <= i_vert.dx * i_vert.sn;
            r_vx      <= i_vert.vx;
            r_vy      <= i_vert.vy;
            r_ax      <= i_vert.ax;
            r_ay      <= i_vert.ay;
            r_pcorner <= i_vert.corner;
            r_pu      <= i_vert.u;
            r_pv      <= i_vert.v;
            r_prot    <= i_vert.rot;
        end
    end

    // round half up to Q.8, add the anchor back and bypass unrotated vertices
    always_comb begin
        sum_x = {r_xc[48], r_xc} + {r_ys[48], r_ys} + 50'sd16384;
        sum_y = {r_yc[48], r_yc} - {r_xs[48], r_xs} + 50'sd16384;
        rot_x = $signed({{2{sum_x[49]}}, sum_x[49:15]})
              + $signed({{13{r_ax[15]}}, r_ax, 8'b0});
        rot_y = $signed({{2{sum_y[49]}}, sum_y[49:15]})
              + $signed({{13{r_ay[15]}}, r_ay, 8'b0});
        n_x   = r_prot ? rot_x : $signed({{5{r_vx[31]}}, r_vx});
        n_y   = r_prot ? rot_y : $signed({{5{r_vy[31]}}, r_vy});
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_pvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_corner <= r_pcorner;
            r_vert_x <= f_sat_vert(n_x);
            r_vert_y <= f_sat_vert(n_y);
            r_tex_u  <= r_pu;
            r_tex_v  <= r_pv;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_corner    = r_corner;
    assign o_vert_x    = r_vert_x;
    assign o_vert_y    = r_vert_y;
    assign o_tex_u     = r_tex_u;
    assign o_tex_v     = r_tex_v;
    assign o_last      = (r_corner == CORNER_BR);

endmodule
